// File: hw/rtl/zssd_pkg.sv
`default_nettype none

package zssd_pkg;

  // Stream parse position.
  typedef enum logic [2:0] {
    PH_CMF,
    PH_FLG,
    PH_BLKHDR,
    PH_LENS,
    PH_PAYLOAD,
    PH_TRAILER,
    PH_DONE,
    PH_ERROR
  } phase_t;

  // Final status codes reported in a status result.
  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SHORT     = 4'd1,
    ST_BADHDR    = 4'd2,
    ST_DICT      = 4'd3,
    ST_NOTSTORED = 4'd4,
    ST_LENMIS    = 4'd5,
    ST_OVERFLOW  = 4'd6,
    ST_TRUNC     = 4'd7,
    ST_TRAILING  = 4'd8,
    ST_CHECKSUM  = 4'd9
  } status_t;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Adler-32 modulus and stream constants.
  localparam logic [16:0] ADLER_MOD     = 17'd65521;
  localparam logic [3:0]  CM_DEFLATE    = 4'd8;
  localparam logic [2:0]  MIN_STREAM    = 3'd6;
  localparam logic [7:0]  FDICT_MASK    = 8'h20;
  localparam logic [7:0]  BTYPE_MASK    = 8'h06;
  localparam logic [7:0]  PAD_MASK      = 8'hF8;
  localparam logic [31:0] CAPACITY_INIT = 32'hFFFF_FFFF;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic [3:0]  status;
    logic [31:0] out_count;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/zssd_in_if.sv
`default_nettype none

interface zssd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/zssd_out_if.sv
`default_nettype none

interface zssd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic [3:0]  status;
  logic [31:0] out_count;

  modport source (output valid, output kind, output out_byte, output status,
                  output out_count, input ready);
  modport sink (input valid, input kind, input out_byte, input status,
                input out_count, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/zssd_cfg_if.sv
`default_nettype none

interface zssd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_capacity;

  modport source (output valid, output out_capacity, input ready);
  modport sink (input valid, input out_capacity, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/zssd_parse.sv
`default_nettype none

module zssd_parse
  import zssd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_take,
  input  wire logic [7:0]  in_byte,
  input  wire logic        end_of_stream,
  input  wire logic [31:0] out_capacity,
  output logic             res_valid,
  output result_t          res
);

  phase_t      phase, phase_next;
  logic [7:0]  header_byte, header_byte_next;
  logic        final_block_seen, final_block_seen_next;
  logic [1:0]  field_index, field_index_next;
  logic [15:0] length_word, length_word_next;
  logic [15:0] complement_word, complement_word_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [15:0] sum_low, sum_low_next;
  logic [15:0] sum_high, sum_high_next;
  logic [31:0] trailer_shift, trailer_shift_next;
  logic [31:0] decoded_count, decoded_count_next;
  logic [2:0]  input_count, input_count_next;
  status_t     error_code, error_code_next;

  // Header check: CMF*256+FLG divisible by 31, folded in 5-bit chunks (32 = 1 mod 31).
  logic [15:0] hdr_word;
  logic [6:0]  fold_a;
  logic [5:0]  fold_b;
  logic        hdr_mod_ok;

  assign hdr_word   = {header_byte, in_byte};
  assign fold_a     = 7'(hdr_word[4:0]) + 7'(hdr_word[9:5]) + 7'(hdr_word[14:10])
                      + 7'(hdr_word[15]);
  assign fold_b     = 6'(fold_a[4:0]) + 6'(fold_a[6:5]);
  assign hdr_mod_ok = (fold_b == 6'd0) || (fold_b == 6'd31);

  // Stored block header and length field checks.
  logic        blk_bad;
  logic [15:0] len_cand, cmp_cand;
  logic        len_mismatch, len_overflow;

  assign blk_bad  = ((in_byte & BTYPE_MASK) != 8'd0) || ((in_byte & PAD_MASK) != 8'd0);
  assign len_cand = length_word;
  assign cmp_cand = {in_byte, complement_word[7:0]};
  assign len_mismatch = (len_cand ^ 16'hFFFF) != cmp_cand;
  assign len_overflow = (33'(decoded_count) + 33'(len_cand)) > 33'(out_capacity);

  // Adler-32 update: each sum stays below twice the modulus, so one subtract fixes it.
  logic [16:0] low_sum, low_mod, high_sum, high_mod;
  logic [15:0] remain_dec;

  assign low_sum    = 17'(sum_low) + 17'(in_byte);
  assign low_mod    = (low_sum >= ADLER_MOD) ? (low_sum - ADLER_MOD) : low_sum;
  assign high_sum   = 17'(sum_high) + low_mod;
  assign high_mod   = (high_sum >= ADLER_MOD) ? (high_sum - ADLER_MOD) : high_sum;
  assign remain_dec = bytes_remaining - 16'd1;

  // Trailer comparison against the running checksum.
  logic [31:0] trailer_new;
  logic        trailer_bad;

  assign trailer_new = {trailer_shift[23:0], in_byte};
  assign trailer_bad = trailer_new != {sum_high, sum_low};

  // Next parse position.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_CMF: begin
        phase_next = (in_byte[3:0] != CM_DEFLATE) ? PH_ERROR : PH_FLG;
      end
      PH_FLG: begin
        if (!hdr_mod_ok || ((in_byte & FDICT_MASK) != 8'd0)) begin
          phase_next = PH_ERROR;
        end else begin
          phase_next = PH_BLKHDR;
        end
      end
      PH_BLKHDR: begin
        phase_next = blk_bad ? PH_ERROR : PH_LENS;
      end
      PH_LENS: begin
        if (field_index == 2'd3) begin
          if (len_mismatch || len_overflow) begin
            phase_next = PH_ERROR;
          end else if (len_cand == 16'd0) begin
            phase_next = final_block_seen ? PH_TRAILER : PH_BLKHDR;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (remain_dec == 16'd0) begin
          phase_next = final_block_seen ? PH_TRAILER : PH_BLKHDR;
        end
      end
      PH_TRAILER: begin
        if (field_index == 2'd3) begin
          phase_next = trailer_bad ? PH_ERROR : PH_DONE;
        end
      end
      PH_DONE: begin
        phase_next = PH_ERROR;
      end
      PH_ERROR: begin
        phase_next = PH_ERROR;
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase
    if (end_of_stream) begin
      phase_next = PH_CMF;
    end
  end

  // Datapath updates and result generation.
  always_comb begin
    header_byte_next      = header_byte;
    final_block_seen_next = final_block_seen;
    field_index_next      = field_index;
    length_word_next      = length_word;
    complement_word_next  = complement_word;
    bytes_remaining_next  = bytes_remaining;
    sum_low_next          = sum_low;
    sum_high_next         = sum_high;
    trailer_shift_next    = trailer_shift;
    decoded_count_next    = decoded_count;
    error_code_next       = error_code;
    input_count_next      = (input_count < MIN_STREAM) ? input_count + 3'd1 : input_count;
    res_valid             = 1'b0;
    res.kind              = KIND_PAYLOAD;
    res.out_byte          = 8'd0;
    res.status            = ST_OK;
    res.out_count         = 32'd0;

    unique case (phase)
      PH_CMF: begin
        header_byte_next = in_byte;
        if (in_byte[3:0] != CM_DEFLATE) begin
          error_code_next = ST_BADHDR;
        end
      end
      PH_FLG: begin
        if (!hdr_mod_ok) begin
          error_code_next = ST_BADHDR;
        end else if ((in_byte & FDICT_MASK) != 8'd0) begin
          error_code_next = ST_DICT;
        end
      end
      PH_BLKHDR: begin
        if (blk_bad) begin
          error_code_next = ST_NOTSTORED;
        end else begin
          final_block_seen_next = in_byte[0];
          field_index_next      = 2'd0;
          length_word_next      = 16'd0;
          complement_word_next  = 16'd0;
        end
      end
      PH_LENS: begin
        case (field_index)
          2'd0:    length_word_next = {8'd0, in_byte};
          2'd1:    length_word_next = {in_byte, length_word[7:0]};
          2'd2:    complement_word_next = {8'd0, in_byte};
          default: complement_word_next = cmp_cand;
        endcase
        if (field_index != 2'd3) begin
          field_index_next = field_index + 2'd1;
        end else if (len_mismatch) begin
          error_code_next = ST_LENMIS;
        end else if (len_overflow) begin
          error_code_next = ST_OVERFLOW;
        end else if (len_cand == 16'd0) begin
          field_index_next = 2'd0;
        end else begin
          bytes_remaining_next = len_cand;
        end
      end
      PH_PAYLOAD: begin
        sum_low_next         = low_mod[15:0];
        sum_high_next        = high_mod[15:0];
        decoded_count_next   = decoded_count + 32'd1;
        bytes_remaining_next = remain_dec;
        if (remain_dec == 16'd0) begin
          field_index_next = 2'd0;
        end
        res_valid     = 1'b1;
        res.out_byte  = in_byte;
        res.out_count = decoded_count_next;
      end
      PH_TRAILER: begin
        trailer_shift_next = trailer_new;
        if (field_index != 2'd3) begin
          field_index_next = field_index + 2'd1;
        end else if (trailer_bad) begin
          error_code_next = ST_CHECKSUM;
        end
      end
      PH_DONE: begin
        error_code_next = ST_TRAILING;
      end
      PH_ERROR: begin
      end
      default: begin
      end
    endcase

    // The last byte closes the stream with one status result and a fresh state.
    if (end_of_stream) begin
      res_valid    = 1'b1;
      res.kind     = KIND_STATUS;
      res.out_byte = 8'd0;
      res.out_count = decoded_count_next;
      if (input_count_next < MIN_STREAM) begin
        res.status = ST_SHORT;
      end else if (error_code_next != ST_OK) begin
        res.status = error_code_next;
      end else if (phase_next != PH_DONE && !(phase == PH_TRAILER && field_index == 2'd3)) begin
        res.status = ST_TRUNC;
      end else if (phase == PH_DONE) begin
        res.status = ST_OK;
      end else begin
        res.status = ST_OK;
      end
      header_byte_next      = 8'd0;
      final_block_seen_next = 1'b0;
      field_index_next      = 2'd0;
      length_word_next      = 16'd0;
      complement_word_next  = 16'd0;
      bytes_remaining_next  = 16'd0;
      sum_low_next          = 16'd1;
      sum_high_next         = 16'd0;
      trailer_shift_next    = 32'd0;
      decoded_count_next    = 32'd0;
      input_count_next      = 3'd0;
      error_code_next       = ST_OK;
    end
  end

  // State registers, updated on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_CMF;
      header_byte      <= 8'd0;
      final_block_seen <= 1'b0;
      field_index      <= 2'd0;
      length_word      <= 16'd0;
      complement_word  <= 16'd0;
      bytes_remaining  <= 16'd0;
      sum_low          <= 16'd1;
      sum_high         <= 16'd0;
      trailer_shift    <= 32'd0;
      decoded_count    <= 32'd0;
      input_count      <= 3'd0;
      error_code       <= ST_OK;
    end else if (item_take) begin
      phase            <= phase_next;
      header_byte      <= header_byte_next;
      final_block_seen <= final_block_seen_next;
      field_index      <= field_index_next;
      length_word      <= length_word_next;
      complement_word  <= complement_word_next;
      bytes_remaining  <= bytes_remaining_next;
      sum_low          <= sum_low_next;
      sum_high         <= sum_high_next;
      trailer_shift    <= trailer_shift_next;
      decoded_count    <= decoded_count_next;
      input_count      <= input_count_next;
      error_code       <= error_code_next;
    end
  end

  // The error state always carries the code of the first failure.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERROR) |-> (error_code != ST_OK))
    else $error("error phase without an error code");

  // The byte counter saturates at the minimum stream length.
  assert property (@(posedge clk) disable iff (rst) input_count <= MIN_STREAM)
    else $error("input byte counter beyond saturation");

  // A block in payload always has bytes left to pass.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_remaining != 16'd0))
    else $error("payload phase with no bytes remaining");

endmodule

`default_nettype wire

// File: hw/rtl/zlib_stored_stream_deframer.sv
// Stored-block zlib stream deframer.
// The stream channel carries one byte of a zlib stream per transfer, with
// end_of_stream marking the last byte. The header, the stored block framing
// and the Adler-32 trailer are checked; payload bytes leave on the result
// channel as kind 0 results, and the byte marked end_of_stream gives one
// kind 1 status result with the total decoded count. The block then starts
// over on a new stream.
// The cfg channel writes out_capacity, the largest decoded total a stream may
// reach; it is always ready. It is to be written only while the block is
// idle; the block itself does not enforce this. Throughput: one byte per
// cycle while the skid register is empty; the parse and checksum update finish
// in the cycle the byte is accepted, and results are registered in a two-entry
// output buffer (an output register and a skid register).
// Reset clears the parse state, empties the output buffer and sets
// out_capacity to all ones. When the receiver stalls, the skid register
// absorbs one more result; the stream channel drops ready once both
// entries are full and raises it again as soon as the output register drains.

`default_nettype none

module zlib_stored_stream_deframer
  import zssd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  zssd_in_if.sink     stream,
  zssd_cfg_if.sink    cfg,
  zssd_out_if.source  result
);

  logic [31:0] out_capacity;
  logic        push, pop;
  logic        new_valid;
  result_t     new_res;
  logic        out_valid, skid_valid;
  result_t     out_data, skid_data;

  // Configuration register write.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAPACITY_INIT;
    end else if (cfg.valid && cfg.ready) begin
      out_capacity <= cfg.out_capacity;
    end
  end

  // Byte parser and checksum.
  zssd_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .item_take     (stream.valid && stream.ready),
    .in_byte       (stream.in_byte),
    .end_of_stream (stream.end_of_stream),
    .out_capacity  (out_capacity),
    .res_valid     (new_valid),
    .res           (new_res)
  );

  // Two-entry output buffer: the stream stalls only when the skid entry is full.
  assign stream.ready = !skid_valid;
  assign push         = stream.valid && stream.ready && new_valid;
  assign pop          = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        if (out_valid) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= skid_valid ? skid_data : new_res;
    end else if (push && !out_valid) begin
      out_data <= new_res;
    end
    if (push && out_valid && !pop) begin
      skid_data <= new_res;
    end
  end

  assign result.valid     = out_valid;
  assign result.kind      = out_data.kind;
  assign result.out_byte  = out_data.out_byte;
  assign result.status    = out_data.status;
  assign result.out_count = out_data.out_count;

  // The skid entry only fills behind a held output entry.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry full while output entry empty");

  // A result pushed into an empty buffer appears at the output next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (push && !out_valid) |=> out_valid)
    else $error("pushed result lost");

  // Payload results never carry a status code.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.kind == KIND_PAYLOAD)) |-> (out_data.status == ST_OK))
    else $error("payload result with nonzero status");

endmodule

`default_nettype wire
